[src/mfps_pkg.sv]
// shared types and constants for the minimum falling path sum block
package mfps_pkg;

	localparam int VALUE_W = 16;
	localparam int SUM_W   = 32;
	localparam int SIZE_W  = 7;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 3;

	// register map (byte addresses)
	localparam logic [ADDR_W-1:0] REG_SIZE = 3'd0;

	localparam logic signed [SUM_W-1:0] SUM_MAX = 32'sh7FFF_FFFF;

	// where an item sits in the matrix
	typedef struct packed {
		logic first_row;
		logic last_row;
		logic first_col;
		logic last_col;
	} mfps_pos_t;

	typedef struct packed {
		logic at_origin;
		logic q_full;
	} mfps_front_stat_t;

	typedef struct packed {
		logic s1_valid;
		logic end_done;
	} mfps_back_stat_t;

endpackage

[src/min_falling_path_sum.sv]
// top level of the streaming minimum falling path sum block
//
// takes a square signed matrix one item per cycle, row by row and left to right, and
// after the last item of the last row offers one result: the least falling path sum.
// the matrix side is set in the size register (byte address 0; 0 acts as 1, above
// N_MAX acts as N_MAX); writing it restarts the matrix. items are taken back to back,
// one per clock while the queue has room; the front end tags each item with its row
// and column and parks it in a two-entry queue, the back end reads the previous row's
// sums at columns j and j+1 from a dual-read row memory, takes the least of the up to
// three neighbours, adds the item and writes the new sum back in place. the last item
// passes the queue, then the memory read, then the result register loads.
// the row memory needs no clearing pass: each entry is written in one row before the
// next row reads it. a waiting result stalls the back end only on a matrix's last
// item, so new items keep flowing while a result is held
module min_falling_path_sum #(
	parameter int N_MAX = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [mfps_pkg::ADDR_W-1:0]         paddr,
	input  logic [mfps_pkg::DATA_W-1:0]         pwdata,
	output logic [mfps_pkg::DATA_W-1:0]         prdata,
	output logic                                pready,
	// items in
	input  logic                                push,
	output logic                                full,
	input  logic signed [mfps_pkg::VALUE_W-1:0] value,
	// results out
	output logic                                empty,
	input  logic                                pop,
	output logic signed [mfps_pkg::SUM_W-1:0]   min_sum
);
	import mfps_pkg::*;

	// column index width
	localparam int CW = (N_MAX > 1) ? $clog2(N_MAX) : 1;

	logic [SIZE_W-1:0] size_q;
	logic              cfg_wr;

	logic                      q_valid, deq;
	logic signed [VALUE_W-1:0] q_value;
	logic [CW-1:0]             q_col;
	mfps_pos_t                 q_pos;
	mfps_front_stat_t          front_stat;
	mfps_back_stat_t           back_stat;

	// size register; a write to it abandons the matrix in progress
	assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_SIZE);
	assign pready = 1'b1;
	assign prdata = (paddr == REG_SIZE) ? DATA_W'(size_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_W'(1);
		end else if (cfg_wr) begin
			size_q <= pwdata[SIZE_W-1:0];
		end
	end

	// front end: position tagging and item queue
	mfps_front #(
		.N_MAX (N_MAX),
		.CW    (CW)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr     (cfg_wr),
		.size    (size_q),
		.push    (push),
		.value   (value),
		.full    (full),
		.deq     (deq),
		.q_valid (q_valid),
		.q_value (q_value),
		.q_col   (q_col),
		.q_pos   (q_pos),
		.stat    (front_stat)
	);

	// back end: row memory, neighbour minimum, sum and result register
	mfps_back #(
		.N_MAX (N_MAX),
		.CW    (CW)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr     (cfg_wr),
		.q_valid (q_valid),
		.q_value (q_value),
		.q_col   (q_col),
		.q_pos   (q_pos),
		.deq     (deq),
		.empty   (empty),
		.pop     (pop),
		.min_sum (min_sum),
		.stat    (back_stat)
	);

	// the queue only fills while the back end holds a stalled item
	a_full_needs_busy_back: assert property (@(posedge clk) disable iff (!arst_n)
		front_stat.q_full |-> back_stat.s1_valid)
		else $error("item queue full while back end is empty");

	// a size write restarts the matrix at row 0, column 0
	a_cfg_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> front_stat.at_origin)
		else $error("position not cleared by size write");

	// a result shows up only after a matrix's last item has finished
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && $past(empty)) |-> $past(back_stat.end_done))
		else $error("result appeared without a finished matrix");

endmodule

[src/mfps_ram.sv]
// generic single-write, dual-read memory with registered read data
module mfps_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr0,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr1,
	output logic [WIDTH-1:0]                      rdata0,
	output logic [WIDTH-1:0]                      rdata1
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata0 <= mem[raddr0];
			rdata1 <= mem[raddr1];
		end
	end

endmodule

[src/mfps_front.sv]
// front end: takes items, tags their matrix position, queues them for the back end
module mfps_front #(
	parameter int N_MAX = 64,
	parameter int CW    = 6
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              clr,
	input  logic [mfps_pkg::SIZE_W-1:0]       size,
	input  logic                              push,
	input  logic signed [mfps_pkg::VALUE_W-1:0] value,
	output logic                              full,
	input  logic                              deq,
	output logic                              q_valid,
	output logic signed [mfps_pkg::VALUE_W-1:0] q_value,
	output logic [CW-1:0]                     q_col,
	output mfps_pkg::mfps_pos_t               q_pos,
	output mfps_pkg::mfps_front_stat_t        stat
);
	import mfps_pkg::*;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic [CW-1:0]             col;
		mfps_pos_t                 pos;
	} entry_t;

	logic [CW-1:0]     row_q, col_q, lim;
	logic [SIZE_W-1:0] size_m1;
	mfps_pos_t         pos;
	logic              accept;

	entry_t     ent_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	// last index of the matrix, size clamped to 1..N_MAX
	always_comb begin
		size_m1 = size - SIZE_W'(1);
		if (size == '0) begin
			lim = '0;
		end else if (32'(size) > N_MAX) begin
			lim = CW'(N_MAX - 1);
		end else begin
			lim = CW'(size_m1);
		end
	end

	assign full   = (count_q == 2'd2);
	assign accept = push && !full;

	always_comb begin
		pos.first_row = (row_q == '0);
		pos.last_row  = (row_q == lim);
		pos.first_col = (col_q == '0);
		pos.last_col  = (col_q == lim);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (clr) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (pos.last_col) begin
				col_q <= '0;
				row_q <= pos.last_row ? '0 : row_q + CW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// two-entry queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (accept) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (deq) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (accept && !deq) begin
				count_q <= count_q + 2'd1;
			end else if (deq && !accept) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ent_q[wr_ptr_q] <= '{value: value, col: col_q, pos: pos};
		end
	end

	assign q_valid = (count_q != 2'd0);
	assign q_value = ent_q[rd_ptr_q].value;
	assign q_col   = ent_q[rd_ptr_q].col;
	assign q_pos   = ent_q[rd_ptr_q].pos;

	assign stat.at_origin = (row_q == '0) && (col_q == '0);
	assign stat.q_full    = full;

endmodule

[src/mfps_back.sv]
// back end: row memory lookup, three-way minimum, add, final-row minimum and result register
module mfps_back #(
	parameter int N_MAX = 64,
	parameter int CW    = 6
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                clr,
	input  logic                                q_valid,
	input  logic signed [mfps_pkg::VALUE_W-1:0] q_value,
	input  logic [CW-1:0]                       q_col,
	input  mfps_pkg::mfps_pos_t                 q_pos,
	output logic                                deq,
	output logic                                empty,
	input  logic                                pop,
	output logic signed [mfps_pkg::SUM_W-1:0]   min_sum,
	output mfps_pkg::mfps_back_stat_t           stat
);
	import mfps_pkg::*;

	logic                      s1_valid_q;
	logic signed [VALUE_W-1:0] value_s1;
	logic [CW-1:0]             col_s1;
	mfps_pos_t                 pos_s1;
	logic                      fwd0_s1, fwd1_s1;
	logic signed [SUM_W-1:0]   fwd_data_s1;

	logic signed [SUM_W-1:0] rd0, rd1, above, right, best, sum;
	logic signed [SUM_W-1:0] left_q, run_min_q, min_sum_q;
	logic                    out_valid_q;
	logic                    is_end, adv;
	logic [CW-1:0]           raddr1;

	assign is_end = pos_s1.first_row & 1'b0 | (pos_s1.last_row && pos_s1.last_col);
	assign adv    = s1_valid_q && (!is_end || !out_valid_q || pop);
	assign deq    = q_valid && (!s1_valid_q || adv);

	// right-hand neighbour; at the last column it is never used
	assign raddr1 = q_pos.last_col ? q_col : q_col + CW'(1);

	mfps_ram #(
		.WIDTH (SUM_W),
		.DEPTH (N_MAX)
	) u_row_ram (
		.clk    (clk),
		.we     (adv),
		.waddr  (col_s1),
		.wdata  (sum),
		.re     (deq),
		.raddr0 (q_col),
		.raddr1 (raddr1),
		.rdata0 (rd0),
		.rdata1 (rd1)
	);

	// forwarding covers the write that lands in the same cycle as the read
	always_comb begin
		above = fwd0_s1 ? fwd_data_s1 : rd0;
		right = fwd1_s1 ? fwd_data_s1 : rd1;
		if (pos_s1.first_row) begin
			above = '0;
		end
		best = above;
		if (!pos_s1.first_col && left_q < best) begin
			best = left_q;
		end
		if (!pos_s1.last_col && right < best) begin
			best = right;
		end
		if (pos_s1.first_row) begin
			best = '0;
		end
		sum = SUM_W'(value_s1) + best;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (deq) begin
			s1_valid_q <= 1'b1;
		end else if (adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (deq) begin
			value_s1    <= q_value;
			col_s1      <= q_col;
			pos_s1      <= q_pos;
			fwd0_s1     <= adv && (col_s1 == q_col);
			fwd1_s1     <= adv && (col_s1 == raddr1);
			fwd_data_s1 <= sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q    <= '0;
			run_min_q <= SUM_MAX;
		end else if (clr) begin
			left_q    <= '0;
			run_min_q <= SUM_MAX;
		end else if (adv) begin
			left_q <= above;
			if (is_end) begin
				run_min_q <= SUM_MAX;
			end else if (pos_s1.last_row && sum < run_min_q) begin
				run_min_q <= sum;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && is_end) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && is_end) begin
			min_sum_q <= (sum < run_min_q) ? sum : run_min_q;
		end
	end

	assign empty   = !out_valid_q;
	assign min_sum = min_sum_q;

	assign stat.s1_valid = s1_valid_q;
	assign stat.end_done = adv && is_end;

endmodule

[tb/min_falling_path_sum_test.sv]
// testbench for the minimum falling path sum block: path sum scoreboard class and top module

class path_sum_scoreboard;
	localparam int ROW_MAX = 64;

	logic signed [mfps_pkg::SUM_W-1:0] row_sums [ROW_MAX];
	logic signed [mfps_pkg::SUM_W-1:0] left_above;
	logic signed [mfps_pkg::SUM_W-1:0] last_row_min;
	int unsigned                       row_pos;
	int unsigned                       col_pos;
	logic [mfps_pkg::SIZE_W-1:0]       size_reg;
	logic signed [mfps_pkg::SUM_W-1:0] expected_sums [$];
	int                                failures;

	function new();
		foreach (row_sums[i]) row_sums[i] = '0;
		size_reg = mfps_pkg::SIZE_W'(1);
		failures = 0;
		restart();
	endfunction

	function void restart();
		left_above   = '0;
		row_pos      = 0;
		col_pos      = 0;
		last_row_min = mfps_pkg::SUM_MAX;
	endfunction

	// 0 acts as 1, anything above the row memory depth acts as the depth
	function int unsigned side();
		if (size_reg == 0) return 1;
		if (size_reg > ROW_MAX) return ROW_MAX;
		return 32'(size_reg);
	endfunction

	function void set_size(logic [mfps_pkg::SIZE_W-1:0] s);
		size_reg = s;
		restart();
	endfunction

	function void note_item(logic signed [mfps_pkg::VALUE_W-1:0] v);
		int unsigned                       n;
		int unsigned                       j;
		logic signed [mfps_pkg::SUM_W-1:0] above;
		logic signed [mfps_pkg::SUM_W-1:0] best;
		logic signed [mfps_pkg::SUM_W-1:0] sum;
		bit                                last_row;
		bit                                last_col;
		n = side();
		if (row_pos >= n || col_pos >= n) restart();
		j = col_pos;
		if (row_pos == 0) begin
			sum   = mfps_pkg::SUM_W'(v);
			above = '0;
		end else begin
			above = row_sums[j];
			best  = above;
			if (j > 0 && left_above < best) best = left_above;
			if (j + 1 < n && row_sums[j + 1] < best) best = row_sums[j + 1];
			sum = best + mfps_pkg::SUM_W'(v);
		end
		left_above  = above;
		row_sums[j] = sum;
		last_row    = (row_pos + 1 == n);
		last_col    = (j + 1 == n);
		if (last_row && sum < last_row_min) last_row_min = sum;
		if (last_col) begin
			col_pos    = 0;
			left_above = '0;
			if (last_row) begin
				expected_sums.push_back(last_row_min);
				restart();
			end else begin
				row_pos++;
			end
		end else begin
			col_pos++;
		end
	endfunction

	function void check_result(logic signed [mfps_pkg::SUM_W-1:0] got);
		logic signed [mfps_pkg::SUM_W-1:0] want;
		if (expected_sums.size() == 0) begin
			$display("%0t: unexpected min_sum, expected none, actual %0d", $time, got);
			failures++;
			return;
		end
		want = expected_sums.pop_front();
		if (got !== want) begin
			$display("%0t: min_sum mismatch, expected %0d, actual %0d", $time, want, got);
			failures++;
		end
	endfunction

	function int pending();
		return expected_sums.size();
	endfunction

	function void check_leftover();
		if (expected_sums.size() != 0) begin
			$display("%0t: %0d min_sum results missing, expected %0d next, actual none",
				$time, expected_sums.size(), expected_sums[0]);
			failures++;
		end
	endfunction
endclass

module min_falling_path_sum_test;
	import mfps_pkg::*;

	localparam int N_MAX        = 64;
	// drain margin over the path from last item to result
	localparam int SETTLE_CYCLES = 10;
	// longest correct quiet stretch is the receiver hold-off
	localparam int STALL_LIMIT  = 3000;
	localparam int HOLD_CYCLES  = 300;
	localparam int PHASE_ITEMS  = 280;

	localparam logic signed [VALUE_W-1:0] VALUE_MAX = 16'sh7FFF;
	localparam logic signed [VALUE_W-1:0] VALUE_MIN = 16'sh8000;

	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_e;

	logic                       clk;
	logic                       arst_n;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [ADDR_W-1:0]          paddr;
	logic [DATA_W-1:0]          pwdata;
	logic [DATA_W-1:0]          prdata;
	logic                       pready;
	logic                       push;
	logic                       full;
	logic signed [VALUE_W-1:0]  value;
	logic                       empty;
	logic                       pop;
	logic signed [SUM_W-1:0]    min_sum;

	idle_mode_e                 idle_mode = IDLE_NONE;
	int                         recv_hold = 0;
	int                         quiet_cycles = 0;
	path_sum_scoreboard         sb = new();

	min_falling_path_sum #(
		.N_MAX(N_MAX)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.push   (push),
		.full   (full),
		.value  (value),
		.empty  (empty),
		.pop    (pop),
		.min_sum(min_sum)
	);

	// free-running clock, period 20
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// sender gaps: 55 in a hundred alone, 35 when both sides idle
	function automatic bit sender_idles();
		case (idle_mode)
			IDLE_SEND: return $urandom_range(99) < 55;
			IDLE_BOTH: return $urandom_range(99) < 35;
			default:   return 1'b0;
		endcase
	endfunction

	function automatic bit receiver_stalls();
		case (idle_mode)
			IDLE_RECV: return $urandom_range(99) < 55;
			IDLE_BOTH: return $urandom_range(99) < 35;
			default:   return 1'b0;
		endcase
	endfunction

	// element values lean on the two extremes and on values around zero
	function automatic logic signed [VALUE_W-1:0] rand_value();
		case ($urandom_range(7))
			0:       return VALUE_MAX;
			1:       return VALUE_MIN;
			2:       return VALUE_W'($urandom_range(20) - 10);
			default: return VALUE_W'($urandom);
		endcase
	endfunction

	// mostly small sides so that many matrices finish, now and then a zero
	function automatic logic [SIZE_W-1:0] pick_size();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 6) return '0;
		if (r < 70) return SIZE_W'($urandom_range(4, 1));
		return SIZE_W'($urandom_range(10, 5));
	endfunction

	// receiver side: one pop decision per falling edge; the hold-off is counted here
	initial begin
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (recv_hold > 0) begin
				pop <= 1'b0;
				recv_hold = recv_hold - 1;
			end else begin
				pop <= !receiver_stalls();
			end
		end
	end

	// sampling at the rising edge: note accepted items first, then check results
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) sb.note_item(value);
			if (pop && !empty) sb.check_result(min_sum);
			if ((push && !full) || (pop && !empty)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			// watchdog: nothing moved for far longer than any correct stall
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no item or result accepted for %0d cycles", $time, quiet_cycles);
				$display("min_falling_path_sum regression: fail");
				$finish;
			end
		end
	end

	// called at a falling edge, returns at the falling edge after acceptance with push
	// still high, so a following item keeps push up without a gap
	task automatic drive_item(input logic signed [VALUE_W-1:0] v);
		while (sender_idles()) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push  <= 1'b1;
		value <= v;
		@(posedge clk);
		while (full) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drive_random(input int count);
		repeat (count) drive_item(rand_value());
	endtask

	// wait until every expected result has arrived, then let the pipeline settle
	// so that items of an abandoned matrix are through before a register write
	task automatic wait_drained();
		push <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// apb write: setup then access; upper data bits are noise, only seven are held
	task automatic write_size(input logic [SIZE_W-1:0] sz);
		logic [DATA_W-1:0] word;
		word         = $urandom;
		word[SIZE_W-1:0] = sz;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_SIZE;
		pwdata  <= word;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.set_size(word[SIZE_W-1:0]);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// random matrices under one idling mode; sizes change between runs of matrices and
	// now and then a matrix is left unfinished before the next size write
	task automatic run_phase(input idle_mode_e m, input int target);
		int          sent;
		int unsigned n;
		int unsigned matrices;
		idle_mode = m;
		sent      = 0;
		while (sent < target) begin
			write_size(pick_size());
			n        = sb.side();
			matrices = $urandom_range(4, 1);
			repeat (matrices) begin
				drive_random(n * n);
				sent += n * n;
			end
			if (n > 1 && $urandom_range(9) == 0) begin
				drive_random($urandom_range(n * n - 1, 1));
				sent += 1;
			end
			wait_drained();
		end
	endtask

	initial begin
		// every input known from the first instant, reset held at the start
		arst_n  = 1'b0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		push    = 1'b0;
		value   = '0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset side of one, each item is its own matrix
		drive_item(VALUE_MAX);
		drive_item(VALUE_MIN);
		drive_item('0);
		wait_drained();
		// a side of zero acts as one
		write_size('0);
		drive_item(-16'sd1);
		drive_item(16'sd1);
		wait_drained();
		// most negative everywhere, two by two
		write_size(7'd2);
		repeat (4) drive_item(VALUE_MIN);
		wait_drained();
		// three by three with mostly alternating extremes, edge and middle columns
		write_size(7'd3);
		drive_item(VALUE_MAX);
		drive_item(VALUE_MIN);
		drive_item(VALUE_MAX);
		drive_item(VALUE_MIN);
		drive_item(VALUE_MAX);
		drive_item(VALUE_MIN);
		drive_item(VALUE_MAX);
		drive_item(VALUE_MAX);
		drive_item(VALUE_MIN);
		wait_drained();
		// size rewritten mid-matrix: the partial matrix is dropped
		drive_item(16'sd5);
		drive_item(-16'sd7);
		drive_item(16'sd100);
		drive_item(VALUE_MIN);
		wait_drained();
		write_size(7'd2);
		drive_item(16'sd3);
		drive_item(-16'sd4);
		drive_item(VALUE_MAX);
		drive_item(16'sd9);
		wait_drained();

		// long receiver hold-off with items still offered: a result is held and the
		// input side backs up until pops resume
		write_size(7'd1);
		recv_hold = HOLD_CYCLES;
		drive_random(40);
		wait_drained();

		// random phases, one per idling mode
		run_phase(IDLE_NONE, PHASE_ITEMS);
		run_phase(IDLE_SEND, PHASE_ITEMS);
		run_phase(IDLE_RECV, PHASE_ITEMS);
		run_phase(IDLE_BOTH, PHASE_ITEMS);

		// largest side, a few full rows back to back, then the clamped top code with
		// idling; both matrices are left unfinished, a full one would need 4096 items
		idle_mode = IDLE_NONE;
		write_size(7'd64);
		drive_random(3 * N_MAX);
		wait_drained();
		idle_mode = IDLE_BOTH;
		write_size(7'd127);
		drive_random(2 * N_MAX);
		wait_drained();
		// a checked matrix straight after the abandoned large one
		idle_mode = IDLE_NONE;
		write_size(7'd2);
		repeat (4) drive_item(rand_value());
		wait_drained();

		sb.check_leftover();
		if (sb.failures == 0) begin
			$display("min_falling_path_sum regression: pass");
		end else begin
			$display("min_falling_path_sum regression: fail");
		end
		$finish;
	end

endmodule
